// ===== hdl/pstt_pkg.sv =====
// Package for the piecewise speed travel time block: widths, limits, opcodes, config indices, states.
// No dependencies; used by the top level of the block.
`timescale 1ns / 1ps
`default_nettype none
package pstt_pkg;
  localparam int unsigned MaxPieces = 8;
  localparam int unsigned IdxW = $clog2(MaxPieces);
  localparam int unsigned CntW = 4;
  localparam logic [31:0] FxMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_DEPART = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam logic CFG_ARC = 1'b0;
  localparam logic CFG_CNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_RD,
    ST_DIV,
    ST_DECIDE,
    ST_MUL,
    ST_SUB,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/pstt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pstt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read share the one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/piecewise_speed_travel_time.sv =====
// Top level of the piecewise speed travel time block.
// Depends on pstt_pkg and pstt_ram.
`timescale 1ns / 1ps
`default_nettype none
// Usage: a command item is presented on start with its fields and is taken at a clock edge
// where busy is low. A load item writes one piece (end time, speed) into the piece tables
// at that edge and produces no result; busy stays low, so the next item can follow at once.
// An arrival or departure query walks the pieces through one shared sequencer. The piece
// search issues a read of one table entry and then tests it before moving to the next.
// Each piece visited takes table reads of its end and speed (away from piece 0, the start
// of the piece is fetched as well from the end of the piece before), a 48-bit restoring
// division at one quotient bit a cycle and a decide step. If the walk goes on, a 32x32
// multiply and a subtract follow before the next piece is read. The result is on the
// ports with done_o high in the first cycle with busy low, and a new item can be taken at
// the edge that ends that cycle; the receiver cannot stall. Configuration writes (index 0
// arc length, 1 piece count) are taken on cfg_valid_i & cfg_ready_o while idle. Reset
// clears control state and sets the arc length to zero and the piece count to one; the
// piece tables are undefined until loaded.
module piecewise_speed_travel_time
  import pstt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [2:0]  piece_index_i,
  input  wire logic [31:0] piece_end_i,
  input  wire logic [31:0] piece_speed_i,
  input  wire logic [31:0] query_time_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [31:0]      result_time_o,
  output logic             status_o
);
  state_e state_q, state_d;
  logic [31:0] arc_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] n1_q;      // index of last piece in use
  logic dep_q;
  logic [IdxW-1:0] idx_q;
  logic [31:0] t_q, d_q, e_q, s_q, st_q;  // time, distance, end, speed, start
  logic [1:0] rd_q;           // read phase: 2 issue, 0 end/speed of idx, 1 and 3 end of idx-1
  logic [63:0] rem_q;
  logic [47:0] quo_q;
  logic [5:0] bit_q;
  logic [31:0] q_q;
  logic [63:0] prod_q;
  logic [31:0] res_q;
  logic stat_q, done_q;

  // Piece tables.
  logic load_we;
  logic [IdxW-1:0] ram_addr;
  logic [31:0] end_rd, spd_rd;
  assign load_we = (state_q == ST_IDLE) && start && (opcode_i == OP_LOAD);
  always_comb begin
    ram_addr = idx_q;
    if (load_we) ram_addr = piece_index_i;
    else if (rd_q == 2'd1) ram_addr = idx_q - IdxW'(1);
  end
  pstt_ram #(.Width(32), .Depth(MaxPieces)) u_end (
    .clk_i, .we_i(load_we), .addr_i(ram_addr), .wdata_i(piece_end_i), .rdata_o(end_rd));
  pstt_ram #(.Width(32), .Depth(MaxPieces)) u_spd (
    .clk_i, .we_i(load_we), .addr_i(ram_addr), .wdata_i(piece_speed_i), .rdata_o(spd_rd));

  assign busy = state_q != ST_IDLE;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign done_o = done_q;
  assign result_time_o = res_q;
  assign status_o = stat_q;

  // Divider step: restoring, one quotient bit per cycle.
  logic [64:0] trial;
  assign trial = {rem_q, quo_q[47]} - {33'd0, s_q};

  // Combinational helpers for the decide step.
  logic [32:0] at_sum;
  logic [31:0] at_sat;
  logic is_last, dneg;
  logic [31:0] t0;
  assign at_sum = {1'b0, t_q} + {1'b0, q_q};
  assign at_sat = at_sum[32] ? FxMax : at_sum[31:0];
  assign is_last = idx_q == n1_q;
  assign dneg = q_q > t_q;
  assign t0 = dneg ? 32'd0 : t_q - q_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start && (opcode_i == OP_ARRIVE || opcode_i == OP_DEPART))
        state_d = ST_FIND;
      ST_FIND: if (rd_q == 2'd2) state_d = ST_FIND;
        else if (idx_q == n1_q || !(t_q > end_rd) || rd_q == 2'd3) state_d = ST_RD;
      ST_RD: if (rd_q == 2'd2 || (rd_q != 2'd3 && idx_q != '0)) state_d = ST_RD;
        else state_d = ST_DIV;
      ST_DIV: if (bit_q == 6'd0) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!dep_q) state_d = (is_last || !(at_sat > e_q)) ? ST_DONE : ST_MUL;
        else state_d = (idx_q == '0 || (!dneg && t0 >= st_q)) ? ST_DONE : ST_MUL;
      end
      ST_MUL: state_d = ST_SUB;
      ST_SUB: state_d = ST_RD;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and control registers.
  logic [31:0] span;
  logic [31:0] used;
  assign span = dep_q ? ((t_q > st_q) ? t_q - st_q : 32'd0)
                      : ((e_q > t_q) ? e_q - t_q : 32'd0);
  assign used = (prod_q[63:48] != 16'd0) ? FxMax : prod_q[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      arc_q <= '0;
      cnt_q <= CntW'(1);
      done_q <= 1'b0;
      rd_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == CFG_ARC) arc_q <= cfg_data_i;
            else cnt_q <= cfg_data_i[CntW-1:0];
          end
          if (state_d == ST_FIND) begin
            dep_q <= opcode_i == OP_DEPART;
            t_q <= query_time_i;
            d_q <= arc_q;
            idx_q <= '0;
            rd_q <= 2'd2;
            if (cnt_q == '0) n1_q <= '0;
            else if (cnt_q > CntW'(MaxPieces)) n1_q <= IdxW'(MaxPieces - 1);
            else n1_q <= IdxW'(cnt_q - CntW'(1));
          end
        end
        ST_FIND: begin
          // rd 2: address issued, data next cycle (rd 0).
          if (rd_q == 2'd2) rd_q <= 2'd0;
          else if (state_d == ST_RD) rd_q <= 2'd2;
          else begin
            idx_q <= idx_q + IdxW'(1);
            rd_q <= 2'd2;
          end
        end
        ST_RD: begin
          // rd 2 issue; 0 capture end/speed; 1 issue previous end; 3 capture previous end.
          if (rd_q == 2'd2) rd_q <= 2'd0;
          else if (rd_q == 2'd0) begin
            e_q <= end_rd;
            s_q <= spd_rd;
            st_q <= '0;
            rd_q <= 2'd1;
            if (idx_q == '0) begin
              rd_q <= 2'd0;
              rem_q <= '0;
              quo_q <= {d_q, 16'd0};
              bit_q <= 6'd47;
            end
          end else if (rd_q == 2'd3) begin
            st_q <= end_rd;
            rd_q <= 2'd0;
            rem_q <= '0;
            quo_q <= {d_q, 16'd0};
            bit_q <= 6'd47;
          end else begin
            rd_q <= 2'd3;
          end
        end
        ST_DIV: begin
          if (!trial[64]) begin
            rem_q <= trial[63:0];
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            rem_q <= {rem_q[62:0], quo_q[47]};
            quo_q <= {quo_q[46:0], 1'b0};
          end
          bit_q <= bit_q - 6'd1;
        end
        ST_DECIDE: begin
          if (!dep_q) begin
            res_q <= at_sat;
            stat_q <= 1'b0;
          end else begin
            res_q <= t0;
            stat_q <= (idx_q == '0) ? dneg : 1'b0;
          end
          prod_q <= s_q * span;  // registered product
        end
        ST_SUB: begin
          d_q <= (used >= d_q) ? 32'd0 : d_q - used;
          if (dep_q) begin
            if (st_q < t_q) t_q <= st_q;
            idx_q <= idx_q - IdxW'(1);
          end else begin
            if (e_q > t_q) t_q <= e_q;
            idx_q <= idx_q + IdxW'(1);
          end
          rd_q <= 2'd2;
        end
        ST_DONE: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Quotient saturation, taken from the last divider step.
  logic [47:0] quo_fin;
  assign quo_fin = trial[64] ? {quo_q[46:0], 1'b0} : {quo_q[46:0], 1'b1};
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && bit_q == 6'd0) begin
      if (s_q == 32'd0 || quo_fin[47:32] != 16'd0) q_q <= FxMax;
      else q_q <= quo_fin[31:0];
    end
  end

  // Departure results below zero always read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o && status_o |-> result_time_o == 32'd0)
    else $error("negative departure with nonzero time");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == ST_DIV |-> bit_q <= 6'd47)
    else $error("divider bit count out of range");
endmodule
`default_nettype wire
